### rtl/core/psw_pkg.sv
// Shared types and constants for the power-of-two size sweep sequencer.
package psw_pkg;

    localparam int SizeBitsDef     = 16;
    localparam int DurationBitsDef = 24;
    localparam int CfgIndexBits    = 2;

    localparam int LowestReset  = 1;
    localparam int HighestReset = 64;
    localparam int StartReset   = 32;

    localparam logic ACT_START = 1'b0;

    typedef enum logic [1:0] {
        MODE_ADAPTIVE = 2'd0,
        MODE_SHRINK   = 2'd1,
        MODE_GROW     = 2'd2,
        MODE_EVERY    = 2'd3
    } t_mode;

    typedef enum logic [CfgIndexBits-1:0] {
        CFG_MODE    = 2'd0,
        CFG_LOWEST  = 2'd1,
        CFG_HIGHEST = 2'd2,
        CFG_START   = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ADAPTIVE = 3'd1,
        PH_SHRINK   = 3'd2,
        PH_GROW     = 3'd3,
        PH_EVERY    = 3'd4,
        PH_DONE     = 3'd5,
        PH_FAILED   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_NONE   = 2'd1,
        ST_FAILED = 2'd2
    } t_status;

endpackage

### rtl/core/psw_cfg.sv
// Configuration registers and derivation of the effective size range and start size.
module psw_cfg
    import psw_pkg::*;
#(
    parameter int SIZE_BITS = SizeBitsDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CfgIndexBits-1:0] i_cfg_index,
    input  logic [SIZE_BITS-1:0] i_cfg_data,
    output t_mode                o_mode,
    output logic [SIZE_BITS-1:0] o_eff_lowest,
    output logic [SIZE_BITS-1:0] o_eff_highest,
    output logic [SIZE_BITS-1:0] o_start_size
);

    t_mode                r_mode;
    logic [SIZE_BITS-1:0] r_lowest;
    logic [SIZE_BITS-1:0] r_highest;
    logic [SIZE_BITS-1:0] r_start;

    logic [SIZE_BITS-1:0] eff_lo;
    logic [SIZE_BITS-1:0] eff_hi;
    logic [SIZE_BITS-1:0] start_nz;
    logic [SIZE_BITS-1:0] smear;
    logic [SIZE_BITS-1:0] pow2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ADAPTIVE;
            r_lowest  <= SIZE_BITS'(LowestReset);
            r_highest <= SIZE_BITS'(HighestReset);
            r_start   <= SIZE_BITS'(StartReset);
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MODE:    r_mode    <= t_mode'(i_cfg_data[1:0]);
                CFG_LOWEST:  r_lowest  <= i_cfg_data;
                CFG_HIGHEST: r_highest <= i_cfg_data;
                CFG_START:   r_start   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The start size is rounded down to a power of two by smearing its leading one.
    always_comb begin
        eff_lo   = (r_lowest == '0) ? SIZE_BITS'(1) : r_lowest;
        eff_hi   = (r_highest < eff_lo) ? eff_lo : r_highest;
        start_nz = (r_start == '0) ? SIZE_BITS'(1) : r_start;
        smear    = start_nz;
        for (int k = 1; k < SIZE_BITS; k = k * 2) begin
            smear = smear | (smear >> k);
        end
        pow2 = smear & ~(smear >> 1);
        if (pow2 < eff_lo) begin
            pow2 = eff_lo;
        end
        if (pow2 > eff_hi) begin
            pow2 = eff_hi;
        end
    end

    assign o_mode        = r_mode;
    assign o_eff_lowest  = eff_lo;
    assign o_eff_highest = eff_hi;
    assign o_start_size  = pow2;

endmodule

### rtl/core/psw_step.sv
// Sweep state registers and the next-size decision for one start or outcome item.
module psw_step
    import psw_pkg::*;
#(
    parameter int SIZE_BITS     = SizeBitsDef,
    parameter int DURATION_BITS = DurationBitsDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic                     i_action,
    input  logic                     i_trial_made,
    input  logic                     i_trial_held,
    input  logic [DURATION_BITS-1:0] i_trial_duration,
    input  t_mode                    i_mode,
    input  logic [SIZE_BITS-1:0]     i_eff_lowest,
    input  logic [SIZE_BITS-1:0]     i_eff_highest,
    input  logic [SIZE_BITS-1:0]     i_start_size,
    output logic                     o_finished,
    output logic [SIZE_BITS-1:0]     o_size,
    output t_status                  o_status,
    output logic [DURATION_BITS-1:0] o_chosen_duration
);

    t_phase                   r_phase;
    logic [SIZE_BITS-1:0]     r_cur;
    logic [SIZE_BITS-1:0]     r_eff_lo;
    logic [SIZE_BITS-1:0]     r_eff_hi;
    logic                     r_found;
    logic [SIZE_BITS-1:0]     r_best_size;
    logic [DURATION_BITS-1:0] r_best_dur;

    t_phase                   n_phase;
    logic [SIZE_BITS-1:0]     n_cur;
    logic [SIZE_BITS-1:0]     n_eff_lo;
    logic [SIZE_BITS-1:0]     n_eff_hi;
    logic                     n_found;
    logic [SIZE_BITS-1:0]     n_best_size;
    logic [DURATION_BITS-1:0] n_best_dur;

    logic [SIZE_BITS-1:0]     half;
    logic [SIZE_BITS:0]       dbl;
    logic                     can_shrink;
    logic                     can_grow;
    logic                     more;
    logic                     rec;

    assign half       = r_cur >> 1;
    assign dbl        = {r_cur, 1'b0};
    assign can_shrink = (half >= r_eff_lo);
    assign can_grow   = (dbl <= {1'b0, r_eff_hi});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cur       <= '0;
            r_eff_lo    <= SIZE_BITS'(1);
            r_eff_hi    <= SIZE_BITS'(1);
            r_found     <= 1'b0;
            r_best_size <= '0;
            r_best_dur  <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_cur       <= n_cur;
            r_eff_lo    <= n_eff_lo;
            r_eff_hi    <= n_eff_hi;
            r_found     <= n_found;
            r_best_size <= n_best_size;
            r_best_dur  <= n_best_dur;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_cur       = r_cur;
        n_eff_lo    = r_eff_lo;
        n_eff_hi    = r_eff_hi;
        n_found     = r_found;
        n_best_size = r_best_size;
        n_best_dur  = r_best_dur;
        more        = 1'b0;
        rec         = 1'b0;

        if (i_action == ACT_START) begin
            n_eff_lo    = i_eff_lowest;
            n_eff_hi    = i_eff_highest;
            n_found     = 1'b0;
            n_best_size = '0;
            n_best_dur  = '0;
            more        = 1'b1;
            n_cur       = i_start_size;
            case (i_mode)
                MODE_ADAPTIVE: n_phase = PH_ADAPTIVE;
                MODE_SHRINK:   n_phase = PH_SHRINK;
                MODE_GROW:     n_phase = PH_GROW;
                default: begin
                    n_phase = PH_EVERY;
                    n_cur   = i_eff_highest;
                end
            endcase
        end else if (r_phase inside {PH_IDLE, PH_DONE, PH_FAILED}) begin
            more = 1'b0;
        end else if (!i_trial_made) begin
            n_phase = PH_FAILED;
        end else begin
            case (r_phase)
                PH_ADAPTIVE: begin
                    if (i_trial_held) begin
                        rec = 1'b1;
                        if (can_shrink) begin
                            n_phase = PH_SHRINK;
                            n_cur   = half;
                            more    = 1'b1;
                        end
                    end else if (can_grow) begin
                        n_phase = PH_GROW;
                        n_cur   = dbl[SIZE_BITS-1:0];
                        more    = 1'b1;
                    end
                end
                PH_SHRINK: begin
                    if (i_trial_held) begin
                        rec = 1'b1;
                        if (can_shrink) begin
                            n_cur = half;
                            more  = 1'b1;
                        end
                    end
                end
                PH_GROW: begin
                    if (i_trial_held) begin
                        rec = 1'b1;
                    end else if (can_grow) begin
                        n_cur = dbl[SIZE_BITS-1:0];
                        more  = 1'b1;
                    end
                end
                default: begin
                    rec = i_trial_held;
                    if (can_shrink) begin
                        n_cur = half;
                        more  = 1'b1;
                    end
                end
            endcase
            if (rec) begin
                n_found     = 1'b1;
                n_best_size = r_cur;
                n_best_dur  = i_trial_duration;
            end
            if (!more) begin
                n_phase = PH_DONE;
            end
        end

        if (more) begin
            o_finished        = 1'b0;
            o_size            = n_cur;
            o_status          = ST_FOUND;
            o_chosen_duration = '0;
        end else if (n_phase == PH_FAILED) begin
            o_finished        = 1'b1;
            o_size            = '0;
            o_status          = ST_FAILED;
            o_chosen_duration = '0;
        end else if (n_found) begin
            o_finished        = 1'b1;
            o_size            = n_best_size;
            o_status          = ST_FOUND;
            o_chosen_duration = n_best_dur;
        end else begin
            o_finished        = 1'b1;
            o_size            = '0;
            o_status          = ST_NONE;
            o_chosen_duration = '0;
        end
    end

endmodule

### rtl/core/power_of_two_size_sweep.sv
// Top level of the power-of-two size sweep sequencer: input register, step logic, result register.
// One item is taken every clock cycle while the result side is not stalled: the item is held in an
// input register, the sweep decision is made in short logic that updates the sweep state, and the
// result waits in a result register until it is taken.
// A stalled result stops the input side only once the input register is also full.
// Configuration writes take effect at the next start item.
module power_of_two_size_sweep
    import psw_pkg::*;
#(
    parameter int SIZE_BITS     = SizeBitsDef,
    parameter int DURATION_BITS = DurationBitsDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CfgIndexBits-1:0]  i_cfg_index,
    input  logic [SIZE_BITS-1:0]     i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_action,
    input  logic                     i_trial_made,
    input  logic                     i_trial_held,
    input  logic [DURATION_BITS-1:0] i_trial_duration,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_finished,
    output logic [SIZE_BITS-1:0]     o_size,
    output logic [1:0]               o_status,
    output logic [DURATION_BITS-1:0] o_chosen_duration
);

    logic                     r_in_valid;
    logic                     r_action;
    logic                     r_made;
    logic                     r_held;
    logic [DURATION_BITS-1:0] r_dur;

    logic                     r_out_valid;
    logic                     r_finished;
    logic [SIZE_BITS-1:0]     r_size;
    t_status                  r_status;
    logic [DURATION_BITS-1:0] r_chosen_dur;

    logic                     n_finished;
    logic [SIZE_BITS-1:0]     n_size;
    t_status                  n_status;
    logic [DURATION_BITS-1:0] n_chosen_dur;

    t_mode                    mode;
    logic [SIZE_BITS-1:0]     eff_lowest;
    logic [SIZE_BITS-1:0]     eff_highest;
    logic [SIZE_BITS-1:0]     start_size;

    logic                     out_free;
    logic                     fire;
    logic                     in_take;

    assign out_free = !r_out_valid || i_ready;
    assign fire     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || fire;
    assign in_take  = i_valid && o_ready;

    psw_cfg #(
        .SIZE_BITS(SIZE_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mode       (mode),
        .o_eff_lowest (eff_lowest),
        .o_eff_highest(eff_highest),
        .o_start_size (start_size)
    );

    psw_step #(
        .SIZE_BITS    (SIZE_BITS),
        .DURATION_BITS(DURATION_BITS)
    ) u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_action         (r_action),
        .i_trial_made     (r_made),
        .i_trial_held     (r_held),
        .i_trial_duration (r_dur),
        .i_mode           (mode),
        .i_eff_lowest     (eff_lowest),
        .i_eff_highest    (eff_highest),
        .i_start_size     (start_size),
        .o_finished       (n_finished),
        .o_size           (n_size),
        .o_status         (n_status),
        .o_chosen_duration(n_chosen_dur)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_action <= i_action;
            r_made   <= i_trial_made;
            r_held   <= i_trial_held;
            r_dur    <= i_trial_duration;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_finished   <= n_finished;
            r_size       <= n_size;
            r_status     <= n_status;
            r_chosen_dur <= n_chosen_dur;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_finished        = r_finished;
    assign o_size            = r_size;
    assign o_status          = r_status;
    assign o_chosen_duration = r_chosen_dur;

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid)
        else $error("held input item was lost");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("input taken while both registers are full and stalled");

    a_request_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_finished) |-> (o_status == ST_FOUND && o_chosen_duration == '0))
        else $error("trial request carries a status or duration");

    a_no_pick_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished && o_status != ST_FOUND) |->
        (o_size == '0 && o_chosen_duration == '0))
        else $error("finish without a held size reports a size");

    a_fire_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_valid)
        else $error("processed item produced no result");
`endif

endmodule
